>>> design/button_press_duration_classifier_core_defines.svh
// Assertion macros for the button press duration classifier.
// Used by the core; the macros reference clk and rst_n of the including module.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge out of reset
`define BPDC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// ante implies cons in the same cycle
`define BPDC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// ante implies cons in the next cycle
`define BPDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPDC_ASSERT_ALWAYS(label, cond)
`define BPDC_ASSERT_IMP(label, ante, cons)
`define BPDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/bpdc_pkg.sv
// Shared types and constants of the button press duration classifier.
// No dependencies; imported by the core.
package bpdc_pkg;

  // event codes
  localparam logic [2:0] EV_DOWN   = 3'd0;
  localparam logic [2:0] EV_UP     = 3'd1;
  localparam logic [2:0] EV_PRESS  = 3'd2;
  localparam logic [2:0] EV_LONG   = 3'd3;
  localparam logic [2:0] EV_ULTRA  = 3'd4;
  localparam logic [2:0] EV_SINGLE = 3'd5;
  localparam logic [2:0] EV_DOUBLE = 3'd6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ULTRA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 3'd5;

  // results per tick and the saturated hold count
  localparam logic [3:0]  MAX_RESULTS = 4'd9;
  localparam logic [15:0] HOLD_MAX    = 16'hFFFF;

  // one event: button and code
  typedef struct packed {
    logic [1:0] btn;
    logic [2:0] code;
  } evt_t;

endpackage

>>> design/button_press_duration_classifier_core.sv
// Button press duration classifier: per-button hold/repeat counters, event sequencer.
// Depends on bpdc_pkg and button_press_duration_classifier_core_defines.svh.
//
// One input transaction is one scan tick carrying the active-low button levels.
// A small sequencer walks the double-press window and then the buttons one at a
// time, sharing a single 16-bit compare unit for every threshold test, and emits
// the tick's events (at most nine, the final one flagged by out_tlast) through a
// one-deep pending stage and an output register. A tick walks the window state,
// per button the update state and the press states (held) or release states plus
// DOUBLE on a double press, and the flush state; emitting states wait while the
// output is held off by out_tready, and the input is not ready during that walk.
`include "button_press_duration_classifier_core_defines.svh"

module button_press_duration_classifier_core #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: pin_levels[NUM_BUTTONS-1:0], zero padded to whole bytes
  input  logic [((NUM_BUTTONS+7)/8)*8-1:0]     in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: button_index[1:0], event_code[4:2], zeros above
  output logic [7:0]                           out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpdc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bpdc_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int KEY_W = (IDX_W > 2) ? IDX_W : 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WIN   = 4'd1;
  localparam logic [3:0] ST_BTN   = 4'd2;
  localparam logic [3:0] ST_P1    = 4'd3;
  localparam logic [3:0] ST_P2    = 4'd4;
  localparam logic [3:0] ST_P3    = 4'd5;
  localparam logic [3:0] ST_R0    = 4'd6;
  localparam logic [3:0] ST_R1    = 4'd7;
  localparam logic [3:0] ST_R2    = 4'd8;
  localparam logic [3:0] ST_NEXT  = 4'd9;
  localparam logic [3:0] ST_FLUSH = 4'd10;

  // configuration registers
  logic [7:0]  short_r, repeat_r, window_r;
  logic [15:0] long_r, ultra_r;
  logic [1:0]  key_r;

  // per-button and window state
  logic [15:0] hold_r  [NUM_BUTTONS];
  logic [15:0] hold_nxt[NUM_BUTTONS];
  logic [7:0]  phase_r  [NUM_BUTTONS];
  logic [7:0]  phase_nxt[NUM_BUTTONS];
  logic        await_r, await_nxt;
  logic [7:0]  wc_r, wc_nxt;

  // sequencer and working registers
  logic [3:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [NUM_BUTTONS-1:0] levels_r, levels_nxt;
  logic [15:0]            hw_r, hw_nxt;
  logic                   rose_r, rose_nxt;
  logic                   down_r, down_nxt;
  logic                   ges_r, ges_nxt;
  logic [3:0]             cnt_r, cnt_nxt;

  // pending event and output register
  evt_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  evt_t out_evt_r, out_evt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;

  // shared compare unit
  logic [15:0] cmp_a, cmp_b;
  logic        cmp_eq, cmp_lt;

  logic        out_free;
  logic        emit_v;
  evt_t        emit_e;
  logic        pressed;
  logic        key_hit;
  logic [15:0] cur_h;
  logic [7:0]  cur_ph;
  logic [7:0]  ph_inc;
  logic [7:0]  wc_inc;

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  assign out_free = !out_valid_r || out_tready;
  assign pressed  = !levels_r[idx_r];
  assign key_hit  = (KEY_W'(idx_r) == KEY_W'(key_r));
  assign cur_h    = hold_r[idx_r];
  assign cur_ph   = phase_r[idx_r];
  assign ph_inc   = cur_ph + 8'd1;
  assign wc_inc   = wc_r + 8'd1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    levels_nxt    = levels_r;
    hw_nxt        = hw_r;
    rose_nxt      = rose_r;
    down_nxt      = down_r;
    ges_nxt       = ges_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    phase_nxt     = phase_r;
    await_nxt     = await_r;
    wc_nxt        = wc_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_evt_nxt   = out_evt_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    emit_v        = 1'b0;
    emit_e        = '{btn: 2'(idx_r), code: EV_DOWN};
    cmp_a         = hw_r;
    cmp_b         = {8'd0, short_r};

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          levels_nxt = in_tdata[NUM_BUTTONS-1:0];
          cnt_nxt    = '0;
          state_nxt  = ST_WIN;
        end
      end
      // window expiry comes before the buttons
      ST_WIN: begin
        cmp_a = {8'd0, wc_inc};
        cmp_b = {8'd0, window_r};
        if (!await_r) begin
          idx_nxt   = '0;
          state_nxt = ST_BTN;
        end else if (out_free) begin
          if (!cmp_lt) begin
            emit_v    = 1'b1;
            emit_e    = '{btn: key_r, code: EV_SINGLE};
            await_nxt = 1'b0;
            wc_nxt    = '0;
          end else begin
            wc_nxt = wc_inc;
          end
          idx_nxt   = '0;
          state_nxt = ST_BTN;
        end
      end
      // counter update; repeat phase test
      ST_BTN: begin
        cmp_a = {8'd0, ph_inc};
        cmp_b = {8'd0, repeat_r};
        if (pressed) begin
          rose_nxt = (cur_h != HOLD_MAX);
          hw_nxt   = (cur_h != HOLD_MAX) ? cur_h + 16'd1 : cur_h;
          down_nxt = !cmp_lt;
          hold_nxt[idx_r]  = (cur_h != HOLD_MAX) ? cur_h + 16'd1 : cur_h;
          phase_nxt[idx_r] = cmp_lt ? ph_inc : 8'd0;
          state_nxt = ST_P1;
        end else if (cur_h != 16'd0) begin
          hw_nxt = cur_h;
          hold_nxt[idx_r]  = '0;
          phase_nxt[idx_r] = '0;
          state_nxt = ST_R0;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_P1: begin
        cmp_b = {8'd0, short_r};
        if (out_free) begin
          if (down_r || (rose_r && cmp_eq)) begin
            emit_v = 1'b1;
            emit_e = '{btn: 2'(idx_r), code: EV_DOWN};
          end
          state_nxt = ST_P2;
        end
      end
      ST_P2: begin
        cmp_b = long_r;
        if (out_free) begin
          if (rose_r && cmp_eq) begin
            emit_v = 1'b1;
            emit_e = '{btn: 2'(idx_r), code: EV_LONG};
          end
          state_nxt = ST_P3;
        end
      end
      ST_P3: begin
        cmp_b = ultra_r;
        if (out_free) begin
          if (rose_r && cmp_eq) begin
            emit_v = 1'b1;
            emit_e = '{btn: 2'(idx_r), code: EV_ULTRA};
          end
          state_nxt = ST_NEXT;
        end
      end
      // release: hold at least short gives UP
      ST_R0: begin
        cmp_b = {8'd0, short_r};
        if (out_free) begin
          ges_nxt = !cmp_lt;
          if (!cmp_lt) begin
            emit_v = 1'b1;
            emit_e = '{btn: 2'(idx_r), code: EV_UP};
          end
          state_nxt = ST_R1;
        end
      end
      // below long as well gives PRESS, which for the key button drives the double-press window
      ST_R1: begin
        cmp_b = long_r;
        if (out_free) begin
          state_nxt = ST_NEXT;
          if (ges_r && cmp_lt) begin
            emit_v = 1'b1;
            emit_e = '{btn: 2'(idx_r), code: EV_PRESS};
            if (key_hit) begin
              wc_nxt = '0;
              if (await_r) begin
                await_nxt = 1'b0;
                state_nxt = ST_R2;
              end else begin
                await_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_R2: begin
        if (out_free) begin
          emit_v    = 1'b1;
          emit_e    = '{btn: 2'(idx_r), code: EV_DOUBLE};
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_BTN;
        end
      end
      // the held-back event is the final one of the tick
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_evt_nxt   = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // below MAX_RESULTS, a new event goes to pending; the older pending one moves out
    if (emit_v && (cnt_r < MAX_RESULTS)) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_evt_nxt   = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_nxt   = emit_e;
      pend_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + 4'd1;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      await_r     <= 1'b0;
      wc_r        <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_r[i]  <= '0;
        phase_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      await_r     <= await_nxt;
      wc_r        <= wc_nxt;
      hold_r      <= hold_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    levels_r   <= levels_nxt;
    hw_r       <= hw_nxt;
    rose_r     <= rose_nxt;
    down_r     <= down_nxt;
    ges_r      <= ges_nxt;
    pend_r     <= pend_nxt;
    out_evt_r  <= out_evt_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r  <= 8'd4;
      repeat_r <= 8'd20;
      long_r   <= 16'd200;
      ultra_r  <= 16'd500;
      window_r <= 8'd40;
      key_r    <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT:  short_r  <= cfg_wdata[7:0];
        REG_REPEAT: repeat_r <= cfg_wdata[7:0];
        REG_LONG:   long_r   <= cfg_wdata;
        REG_ULTRA:  ultra_r  <= cfg_wdata;
        REG_WINDOW: window_r <= cfg_wdata[7:0];
        REG_KEY:    key_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_evt_r.code, out_evt_r.btn};

  // checks
  `BPDC_ASSERT_IMP(a_idle_no_pending, state_r == ST_IDLE, !pend_v_r)
  `BPDC_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= MAX_RESULTS)
  `BPDC_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == ST_WIN && cnt_r == 4'd0)
  `BPDC_ASSERT_IMP(a_window_closed_zero, !await_r, wc_r == 8'd0)
  `BPDC_ASSERT_IMP(a_pending_means_emitted, pend_v_r, cnt_r != 4'd0)

endmodule
